### hdl/m4m_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4m_pkg: shared definitions for the 4x4 fixed-point matrix multiplier
// Sizes, number format, saturation limits and the tag that travels along
// the shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package m4m_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = DIM * DIM;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam int IDX_W  = $clog2(DIM);
  localparam int CELL_W = $clog2(CELLS);
  localparam int TAG_W  = 2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Control that rides with each product through the MAC pipeline.
  typedef struct packed {
    logic              first_k;   // first term of a dot product
    logic              last_k;    // final term of a dot product
    logic [TAG_W-1:0]  row;
    logic [TAG_W-1:0]  col;
    logic              last_elem; // final element of the result matrix
  } m4m_tag_t;

endpackage

### hdl/m4m_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4m_channels: valid/ready channel interfaces of the matrix multiplier
// One interface for the operand words and one for the result words.
// ----------------------------------------------------------------------------
interface m4m_in_if import m4m_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] a_element;
  logic signed [DATA_W-1:0] b_element;

  modport source (output valid, a_element, b_element, input ready);
  modport sink   (input valid, a_element, b_element, output ready);
endinterface

interface m4m_out_if import m4m_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] product_element;
  logic [TAG_W-1:0]         row_index;
  logic [TAG_W-1:0]         col_index;
  logic                     last_flag;

  modport source (output valid, product_element, row_index, col_index, last_flag,
                  input ready);
  modport sink   (input valid, product_element, row_index, col_index, last_flag,
                  output ready);
endinterface

### hdl/m4m_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4m_mac: shared multiply-accumulate unit
// Registered 32x32 signed multiply, wide accumulator, then arithmetic shift
// by the fraction width and saturation to 32 bits on the finished sum.
// ----------------------------------------------------------------------------
module m4m_mac import m4m_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     op_valid,
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  input  m4m_tag_t                 op_tag,
  output logic                     sum_done,
  output logic signed [DATA_W-1:0] sum_value,
  output m4m_tag_t                 sum_tag
);

  logic                     prod_v_r;
  m4m_tag_t                 prod_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;
  m4m_tag_t                 done_tag_r;

  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-DATA_W:0]    upper;

  assign prod_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      done_r   <= 1'b0;
    end else if (adv) begin
      prod_v_r <= op_valid;
      done_r   <= prod_v_r && prod_tag_r.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= PROD_W'(op_a) * PROD_W'(op_b);
      prod_tag_r <= op_tag;
      done_tag_r <= prod_tag_r;
      if (prod_v_r) begin
        acc_r <= prod_tag_r.first_k ? prod_ext : acc_r + prod_ext;
      end
    end
  end

  // Floor shift, then clamp when the bits above the result's sign disagree.
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    upper   = shifted[ACC_W-1:DATA_W-1];
    if ((&upper) || !(|upper)) begin
      sum_value = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sum_value = SAT_MIN;
    end else begin
      sum_value = SAT_MAX;
    end
  end

  assign sum_done = done_r;
  assign sum_tag  = done_tag_r;

endmodule

### hdl/matrix4_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_multiply: 4x4 signed Q16.16 matrix product R = A x B
// Loads A and B one element pair per word, then computes the 16 dot
// products on one shared MAC and streams R out in row-major order.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word contents
//   in_ch    sink       a_element, b_element (same row-major position)
//   out_ch   source     product_element, row_index, col_index, last_flag
//
// Input words are accepted back to back while loading; the sixteenth word starts
// the product and input is held off until the last result word is taken.
// The single MAC issues one product per cycle while the pipeline is not
// stalled; the last issued term passes the read, multiply, accumulate and
// result registers before the last result word can be taken.
// A stalled result word freezes the whole MAC pipeline once the next sum is
// finished, until the stalled word is taken.
// Reset is synchronous and active low; the operand memories are not cleared.
// ----------------------------------------------------------------------------
module matrix4_multiply import m4m_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  m4m_in_if.sink      in_ch,
  m4m_out_if.source   out_ch
);

  typedef enum logic {
    ST_LOAD,
    ST_CALC
  } state_t;

  state_t state_r;

  // Operand storage, written while loading and read by the sequencer.
  logic signed [DATA_W-1:0] mem_a [CELLS];
  logic signed [DATA_W-1:0] mem_b [CELLS];

  logic [CELL_W-1:0] load_cnt_r;

  // Issue counters: row i, column j, and dot-product term k.
  logic              issue_active_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  k_r;

  logic [CELL_W-1:0] addr_a;
  logic [CELL_W-1:0] addr_b;
  m4m_tag_t          issue_tag;

  // Read stage.
  logic                     rd_v_r;
  m4m_tag_t                 rd_tag_r;
  logic signed [DATA_W-1:0] rd_a_r;
  logic signed [DATA_W-1:0] rd_b_r;

  // Result register.
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;
  m4m_tag_t                 out_tag_r;

  logic                     mac_done;
  logic signed [DATA_W-1:0] mac_value;
  m4m_tag_t                 mac_tag;

  logic in_fire;
  logic out_fire;
  logic adv;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // The pipeline only stops when a finished sum finds the result register
  // still occupied by a word the sink has not taken.
  assign adv = !(mac_done && out_valid_r && !out_ch.ready);

  always_comb begin
    addr_a = CELL_W'(CELL_W'(i_r) * CELL_W'(DIM) + CELL_W'(k_r));
    addr_b = CELL_W'(CELL_W'(k_r) * CELL_W'(DIM) + CELL_W'(j_r));
    issue_tag.first_k   = (k_r == '0);
    issue_tag.last_k    = (k_r == IDX_W'(DIM - 1));
    issue_tag.row       = TAG_W'(i_r);
    issue_tag.col       = TAG_W'(j_r);
    issue_tag.last_elem = (i_r == IDX_W'(DIM - 1)) && (j_r == IDX_W'(DIM - 1));
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_a[load_cnt_r] <= in_ch.a_element;
      mem_b[load_cnt_r] <= in_ch.b_element;
    end
    if (adv) begin
      rd_a_r   <= mem_a[addr_a];
      rd_b_r   <= mem_b[addr_b];
      rd_tag_r <= issue_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      load_cnt_r     <= '0;
      issue_active_r <= 1'b0;
      i_r            <= '0;
      j_r            <= '0;
      k_r            <= '0;
      rd_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (load_cnt_r == CELL_W'(CELLS - 1)) begin
              load_cnt_r     <= '0;
              issue_active_r <= 1'b1;
              state_r        <= ST_CALC;
            end else begin
              load_cnt_r <= load_cnt_r + CELL_W'(1);
            end
          end
        end
        ST_CALC: begin
          if (out_fire && out_tag_r.last_elem) begin
            state_r <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase

      if (adv) begin
        rd_v_r <= issue_active_r;
        if (issue_active_r) begin
          if (k_r == IDX_W'(DIM - 1)) begin
            k_r <= '0;
            if (j_r == IDX_W'(DIM - 1)) begin
              j_r <= '0;
              if (i_r == IDX_W'(DIM - 1)) begin
                i_r            <= '0;
                issue_active_r <= 1'b0;
              end else begin
                i_r <= i_r + IDX_W'(1);
              end
            end else begin
              j_r <= j_r + IDX_W'(1);
            end
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end
      end

      if (mac_done && adv) begin
        out_valid_r <= 1'b1;
        out_data_r  <= mac_value;
        out_tag_r   <= mac_tag;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  m4m_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .op_valid  (rd_v_r),
    .op_a      (rd_a_r),
    .op_b      (rd_b_r),
    .op_tag    (rd_tag_r),
    .sum_done  (mac_done),
    .sum_value (mac_value),
    .sum_tag   (mac_tag)
  );

  assign in_ch.ready            = (state_r == ST_LOAD);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.product_element = out_data_r;
  assign out_ch.row_index       = out_tag_r.row;
  assign out_ch.col_index       = out_tag_r.col;
  assign out_ch.last_flag       = out_tag_r.last_elem;

  // Loading and result delivery never overlap.
  a_load_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("result word pending while loading operands");

  // Taking the final result word reopens the input.
  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.last_flag) |=> in_ch.ready)
    else $error("input not reopened after final result word");

  // The MAC pipeline is empty whenever operands are being loaded.
  a_idle_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (!issue_active_r && !rd_v_r && !mac_done))
    else $error("MAC activity during operand load");

endmodule
